### design/pes2ts_pkg.sv
// Shared constants and types for the PES to TS packetizer.
package pes2ts_pkg;

    localparam int MAX_RES = 13;
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    localparam logic        REG_VIDEO_PID = 1'b0;
    localparam logic        REG_AUDIO_PID = 1'b1;

    localparam logic [7:0]  START_LAST = 8'h01;
    localparam logic [7:0]  SYNC_BYTE  = 8'h47;
    localparam logic [7:0]  PUSI_FLAG  = 8'h40;
    localparam logic [7:0]  AFC_PAY    = 8'h10;
    localparam logic [7:0]  AFC_BOTH   = 8'h30;
    localparam logic [7:0]  AF_BASE    = 8'd183;
    localparam logic [7:0]  STUFF_BYTE = 8'hFF;
    localparam logic [7:0]  SID_PRIV1  = 8'hBD;
    localparam logic [7:0]  SID_AUD_LO = 8'hC0;
    localparam logic [7:0]  SID_AUD_HI = 8'hDF;
    localparam logic [7:0]  SID_VID_LO = 8'hE0;
    localparam logic [7:0]  SID_VID_HI = 8'hEF;
    localparam logic [7:0]  CHUNK_LEN  = 8'd184;
    localparam logic [16:0] PES_HDR    = 17'd6;

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] rep;
        logic       start;
        logic       last;
    } res_t;

    typedef struct packed {
        res_t [MAX_RES-1:0] slot;
        logic [CNT_W-1:0]   count;
    } burst_t;

endpackage

### design/pes_to_ts_packetizer_unit.sv
// Top level of the PES to MPEG-2 transport stream packetizer.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  in      | sink      | in_valid / in_stall  | in_byte
//  out     | source    | out_valid / out_stall| out_byte, repeat_count, ts_start, last
//  cfg     | sink      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An accepted byte waits in the input register until the result buffer is free, then
// the core turns it into 0 to 13 results in one pass and loads them into the buffer.
// While out_stall is low, results leave one per cycle, and a byte with one result or
// none sustains one item per cycle; N results hold the buffer until all of them leave.
// First result is on the outputs once the buffer has loaded the byte's results.
// in_stall rises only while the input register holds a byte the buffer cannot take yet.
// Reset: hunting for a start code, PIDs 0, both continuity counters 0, buffer empty.
module pes_to_ts_packetizer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic [7:0]  repeat_count,
    output logic        ts_start,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);

    logic               in_vld_reg;
    logic [7:0]         in_byte_reg;
    logic [12:0]        video_pid_reg;
    logic [12:0]        audio_pid_reg;
    logic               free;
    logic               go;
    logic               in_take;
    pes2ts_pkg::burst_t burst;
    pes2ts_pkg::res_t   head;

    // config registers must be written only while idle; the block does not enforce this
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            video_pid_reg <= '0;
            audio_pid_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pes2ts_pkg::REG_VIDEO_PID: video_pid_reg <= cfg_data;
                pes2ts_pkg::REG_AUDIO_PID: audio_pid_reg <= cfg_data;
                default:                   video_pid_reg <= video_pid_reg;
            endcase
        end
    end

    // input register: refilled in the same cycle its byte moves on
    assign go       = in_vld_reg && free;
    assign in_stall = in_vld_reg && !free;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (go)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= in_byte;
        end
    end

    pes2ts_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .data      (in_byte_reg),
        .video_pid (video_pid_reg),
        .audio_pid (audio_pid_reg),
        .burst     (burst)
    );

    pes2ts_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (go),
        .burst     (burst),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .head      (head),
        .free      (free)
    );

    assign out_byte     = head.data;
    assign repeat_count = head.rep;
    assign ts_start     = head.start;
    assign last         = head.last;

endmodule

### design/pes2ts_core.sv
// Packetizer state and per-item result generation.
module pes2ts_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic [7:0]          data,
    input  logic [12:0]         video_pid,
    input  logic [12:0]         audio_pid,
    output pes2ts_pkg::burst_t  burst
);

    typedef enum logic [1:0] {PH_HUNT, PH_HEAD, PH_DATA, PH_DROP} phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] window_reg, window_next;
    logic [1:0]  hidx_reg, hidx_next;
    logic [7:0]  sid_reg, sid_next;
    logic [7:0]  lenh_reg, lenh_next;
    logic [16:0] br_reg, br_next;
    logic [7:0]  cpos_reg, cpos_next;
    logic        video_reg, video_next;
    logic        first_reg, first_next;
    logic [3:0]  acnt_reg, acnt_next;
    logic [3:0]  vcnt_reg, vcnt_next;

    logic [16:0] len17;
    logic [16:0] total;
    logic        is_aud, is_vid;
    logic        hdr_en, hv, hfirst, short_h;
    logic [16:0] hbr;
    logic [3:0]  cc;
    logic [12:0] pid;
    logic [7:0]  af;
    logic [pes2ts_pkg::CNT_W-1:0] hn, pn, pidx;
    pes2ts_pkg::res_t hdr [pes2ts_pkg::MAX_RES];
    logic [7:0]  pay [8];

    assign len17  = {1'b0, lenh_reg, data};
    assign total  = len17 + pes2ts_pkg::PES_HDR;
    assign is_aud = (sid_reg inside {[pes2ts_pkg::SID_AUD_LO:pes2ts_pkg::SID_AUD_HI]})
                    || (sid_reg == pes2ts_pkg::SID_PRIV1);
    assign is_vid = sid_reg inside {[pes2ts_pkg::SID_VID_LO:pes2ts_pkg::SID_VID_HI]};

    always_comb
    begin
        phase_next  = phase_reg;
        window_next = window_reg;
        hidx_next   = hidx_reg;
        sid_next    = sid_reg;
        lenh_next   = lenh_reg;
        br_next     = br_reg;
        cpos_next   = cpos_reg;
        video_next  = video_reg;
        first_next  = first_reg;
        hdr_en      = 1'b0;
        hv          = video_reg;
        hfirst      = first_reg;
        hbr         = br_reg;
        pn          = '0;
        for (int i = 0; i < 8; i++)
        begin
            pay[i] = '0;
        end

        case (phase_reg)
            PH_HUNT:
            begin
                if (window_reg == 16'h0000 && data == pes2ts_pkg::START_LAST)
                begin
                    phase_next  = PH_HEAD;
                    hidx_next   = 2'd0;
                    window_next = 16'hFFFF;
                end
                else
                begin
                    window_next = {window_reg[7:0], data};
                end
            end
            PH_HEAD:
            begin
                case (hidx_reg)
                    2'd0:
                    begin
                        sid_next  = data;
                        hidx_next = 2'd1;
                    end
                    2'd1:
                    begin
                        lenh_next = data;
                        hidx_next = 2'd2;
                    end
                    default:
                    begin
                        hidx_next = 2'd0;
                        br_next   = len17;
                        if (!is_aud && !is_vid)
                        begin
                            // unknown id: swallow the payload silently
                            phase_next = (len17 == '0) ? PH_HUNT : PH_DROP;
                        end
                        else
                        begin
                            video_next = is_vid;
                            hdr_en     = 1'b1;
                            hv         = is_vid;
                            hfirst     = 1'b1;
                            hbr        = total;
                            first_next = 1'b0;
                            cpos_next  = 8'd6;
                            pn         = pes2ts_pkg::CNT_W'(6);
                            pay[0]     = 8'h00;
                            pay[1]     = 8'h00;
                            pay[2]     = pes2ts_pkg::START_LAST;
                            pay[3]     = sid_reg;
                            pay[4]     = lenh_reg;
                            pay[5]     = data;
                            phase_next = (len17 == '0) ? PH_HUNT : PH_DATA;
                        end
                        if (len17 == '0)
                        begin
                            window_next = 16'hFFFF;
                        end
                    end
                endcase
            end
            PH_DATA:
            begin
                if (cpos_reg >= pes2ts_pkg::CHUNK_LEN)
                begin
                    hdr_en     = 1'b1;
                    first_next = 1'b0;
                    cpos_next  = 8'd1;
                end
                else
                begin
                    cpos_next = cpos_reg + 8'd1;
                end
                pn      = pes2ts_pkg::CNT_W'(1);
                pay[0]  = data;
                br_next = br_reg - 17'd1;
                if (br_reg == 17'd1)
                begin
                    phase_next  = PH_HUNT;
                    window_next = 16'hFFFF;
                    hidx_next   = 2'd0;
                end
            end
            default:
            begin
                br_next = br_reg - 17'd1;
                if (br_reg == 17'd1)
                begin
                    phase_next  = PH_HUNT;
                    window_next = 16'hFFFF;
                    hidx_next   = 2'd0;
                end
            end
        endcase
    end

    // TS header and adaptation field for the chunk being opened
    always_comb
    begin
        cc      = hv ? vcnt_reg : acnt_reg;
        pid     = hv ? video_pid : audio_pid;
        short_h = hbr < {9'd0, pes2ts_pkg::CHUNK_LEN};
        af      = pes2ts_pkg::AF_BASE - hbr[7:0];

        acnt_next = acnt_reg;
        vcnt_next = vcnt_reg;
        if (hdr_en)
        begin
            if (hv)
            begin
                vcnt_next = vcnt_reg + 4'd1;
            end
            else
            begin
                acnt_next = acnt_reg + 4'd1;
            end
        end

        for (int i = 0; i < pes2ts_pkg::MAX_RES; i++)
        begin
            hdr[i] = '{data: 8'h00, rep: 8'd1, start: 1'b0, last: 1'b0};
        end
        hdr[0].data  = pes2ts_pkg::SYNC_BYTE;
        hdr[0].start = 1'b1;
        hdr[1].data  = (hfirst ? pes2ts_pkg::PUSI_FLAG : 8'h00) | {3'b000, pid[12:8]};
        hdr[2].data  = pid[7:0];
        hdr[3].data  = (short_h ? pes2ts_pkg::AFC_BOTH : pes2ts_pkg::AFC_PAY) | {4'h0, cc};
        hdr[4].data  = af;
        hdr[5].data  = 8'h00;
        hdr[6].data  = pes2ts_pkg::STUFF_BYTE;
        hdr[6].rep   = af - 8'd1;

        if (!hdr_en)
        begin
            hn = '0;
        end
        else if (!short_h)
        begin
            hn = pes2ts_pkg::CNT_W'(4);
        end
        else if (af == 8'd0)
        begin
            hn = pes2ts_pkg::CNT_W'(5);
        end
        else if (af == 8'd1)
        begin
            hn = pes2ts_pkg::CNT_W'(6);
        end
        else
        begin
            hn = pes2ts_pkg::CNT_W'(7);
        end
    end

    // header entries first, then payload bytes
    always_comb
    begin
        pidx        = '0;
        burst.count = hn + pn;
        for (int k = 0; k < pes2ts_pkg::MAX_RES; k++)
        begin
            pidx = pes2ts_pkg::CNT_W'(k) - hn;
            if (pes2ts_pkg::CNT_W'(k) < hn)
            begin
                burst.slot[k] = hdr[k];
            end
            else
            begin
                burst.slot[k] = '{data: pay[pidx[2:0]], rep: 8'd1, start: 1'b0,
                                  last: 1'b0};
            end
            burst.slot[k].last = (pes2ts_pkg::CNT_W'(k) == burst.count - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            window_reg <= 16'hFFFF;
            hidx_reg   <= 2'd0;
            sid_reg    <= 8'h00;
            lenh_reg   <= 8'h00;
            br_reg     <= '0;
            cpos_reg   <= 8'h00;
            video_reg  <= 1'b0;
            first_reg  <= 1'b1;
            acnt_reg   <= 4'h0;
            vcnt_reg   <= 4'h0;
        end
        else if (go)
        begin
            phase_reg  <= phase_next;
            window_reg <= window_next;
            hidx_reg   <= hidx_next;
            sid_reg    <= sid_next;
            lenh_reg   <= lenh_next;
            br_reg     <= br_next;
            cpos_reg   <= cpos_next;
            video_reg  <= video_next;
            first_reg  <= first_next;
            acnt_reg   <= acnt_next;
            vcnt_reg   <= vcnt_next;
        end
    end

endmodule

### design/pes2ts_outq.sv
// Result buffer for one item's burst, one result out per cycle unless stalled.
module pes2ts_outq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  pes2ts_pkg::burst_t burst,
    input  logic               out_stall,
    output logic               out_valid,
    output pes2ts_pkg::res_t   head,
    output logic               free
);

    pes2ts_pkg::res_t [pes2ts_pkg::MAX_RES-1:0] slot_reg;
    logic [pes2ts_pkg::CNT_W-1:0]               cnt_reg;
    logic                                        take;

    assign out_valid = (cnt_reg != '0);
    assign take      = out_valid && !out_stall;
    assign free      = (cnt_reg == '0) || (cnt_reg == pes2ts_pkg::CNT_W'(1) && take);
    assign head      = slot_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load && free)
        begin
            cnt_reg <= burst.count;
        end
        else if (take)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && free)
        begin
            slot_reg <= burst.slot;
        end
        else if (take)
        begin
            for (int i = 0; i < pes2ts_pkg::MAX_RES - 1; i++)
            begin
                slot_reg[i] <= slot_reg[i+1];
            end
        end
    end

endmodule

### design/pes2ts_chk.sv
// Port-level checks for the packetizer, bound to the top level.
module pes2ts_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic [7:0] repeat_count,
    input logic       ts_start,
    input logic       last
);

    // sync byte is always a single 0x47
    a_sync: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ts_start |-> out_byte == pes2ts_pkg::SYNC_BYTE && repeat_count == 8'd1)
        else $error("ts_start on a result that is not a single sync byte");

    // only stuffing repeats, and nothing repeats zero times
    a_rep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> repeat_count != 8'd0 &&
                      (repeat_count == 8'd1 || out_byte == pes2ts_pkg::STUFF_BYTE))
        else $error("bad repeat_count");

    // a TS header always comes with a payload byte after it from the same item
    a_hdr_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ts_start |-> !last)
        else $error("sync byte flagged as last result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("stalled result changed");

endmodule

bind pes_to_ts_packetizer_unit pes2ts_chk u_pes2ts_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .repeat_count (repeat_count),
    .ts_start     (ts_start),
    .last         (last)
);

### dv/tb_pes_to_ts_packetizer_unit.sv
// Self-checking testbench for the PES to transport stream packetizer unit.
module tb_pes_to_ts_packetizer_unit;

    // The first result can leave only after its byte has passed the input
    // register and the result buffer; a byte that makes no result can still
    // be in flight when the last result has left.
    localparam int SETTLE_CYCLES = 8;
    // Stream bytes (audio or video packet bytes) the random test sends at least.
    localparam int RANDOM_ITEMS  = 40;
    localparam int RANDOM_SEGS   = 2;

    typedef enum logic [1:0] {SEEK, HEADER, PAYLOAD, DISCARD} parse_t;
    typedef enum int {FLOW, SPARSE, PERIODIC, HEAVY} stall_t;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte      = 8'h00;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [7:0]  out_byte;
    logic [7:0]  repeat_count;
    logic        ts_start;
    logic        last;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic        cfg_index    = pes2ts_pkg::REG_VIDEO_PID;
    logic [12:0] cfg_data     = 13'd0;

    pes_to_ts_packetizer_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .repeat_count (repeat_count),
        .ts_start     (ts_start),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // Packetizer prediction: mirrors the block's parse state, PID registers
    // and continuity counters. Starts from the reset state.
    // ------------------------------------------------------------------
    logic [12:0] video_pid_m  = 13'd0;
    logic [12:0] audio_pid_m  = 13'd0;
    parse_t      parse_st     = SEEK;
    logic [15:0] hunt_win     = 16'hFFFF;
    logic [1:0]  hdr_idx      = 2'd0;
    logic [7:0]  sid_m        = 8'h00;
    logic [7:0]  len_hi_m     = 8'h00;
    logic [16:0] remaining    = 17'd0;
    logic [7:0]  chunk_pos    = 8'd0;
    logic        video_m      = 1'b0;
    logic        first_m      = 1'b1;
    logic [3:0]  cc_audio     = 4'd0;
    logic [3:0]  cc_video     = 4'd0;

    pes2ts_pkg::res_t step_res[$];   // results of the byte being predicted
    pes2ts_pkg::res_t ts_exp[$];     // TS results still owed by the block

    int failures        = 0;
    int items_sent      = 0;
    int stream_bytes    = 0;
    int results_checked = 0;
    int audio_pkts      = 0;
    int video_pkts      = 0;
    int dropped_pkts    = 0;
    int stuffing_runs   = 0;
    int burst_left      = 0;

    function automatic logic is_audio_id(input logic [7:0] id);
        return (id >= pes2ts_pkg::SID_AUD_LO && id <= pes2ts_pkg::SID_AUD_HI)
               || id == pes2ts_pkg::SID_PRIV1;
    endfunction

    function automatic logic is_video_id(input logic [7:0] id);
        return id >= pes2ts_pkg::SID_VID_LO && id <= pes2ts_pkg::SID_VID_HI;
    endfunction

    function automatic void emit(input logic [7:0] val, input logic [7:0] rep,
                                 input logic start);
        pes2ts_pkg::res_t r;
        r.data  = val;
        r.rep   = rep;
        r.start = start;
        r.last  = 1'b0;
        step_res.push_back(r);
    endfunction

    function automatic void resume_seek();
        parse_st = SEEK;
        hunt_win = 16'hFFFF;
        hdr_idx  = 2'd0;
    endfunction

    // Four header bytes, then for a short chunk the adaptation field:
    // length byte, flag byte if af > 0, and one run-length result for the stuffing if af > 1.
    function automatic void ts_header();
        logic [12:0] pid;
        logic [3:0]  cc;
        logic        short_chunk;
        logic [7:0]  af;
        pid         = video_m ? video_pid_m : audio_pid_m;
        short_chunk = remaining < 17'(pes2ts_pkg::CHUNK_LEN);
        if (video_m)
        begin
            cc       = cc_video;
            cc_video = cc_video + 4'd1;
        end
        else
        begin
            cc       = cc_audio;
            cc_audio = cc_audio + 4'd1;
        end
        emit(pes2ts_pkg::SYNC_BYTE, 8'd1, 1'b1);
        emit((first_m ? pes2ts_pkg::PUSI_FLAG : 8'h00) | {3'b000, pid[12:8]}, 8'd1, 1'b0);
        emit(pid[7:0], 8'd1, 1'b0);
        emit((short_chunk ? pes2ts_pkg::AFC_BOTH : pes2ts_pkg::AFC_PAY) | {4'h0, cc},
             8'd1, 1'b0);
        if (short_chunk)
        begin
            af = pes2ts_pkg::AF_BASE - remaining[7:0];
            emit(af, 8'd1, 1'b0);
            if (af > 8'd0)
                emit(8'h00, 8'd1, 1'b0);
            if (af > 8'd1)
            begin
                emit(pes2ts_pkg::STUFF_BYTE, af - 8'd1, 1'b0);
                stuffing_runs++;
            end
        end
        first_m   = 1'b0;
        chunk_pos = 8'd0;
    endfunction

    function automatic void payload_byte(input logic [7:0] b);
        if (chunk_pos >= pes2ts_pkg::CHUNK_LEN)
            ts_header();
        emit(b, 8'd1, 1'b0);
        chunk_pos = chunk_pos + 8'd1;
        remaining = remaining - 17'd1;
    endfunction

    function automatic void predict_byte(input logic [7:0] b);
        logic [16:0] total;
        step_res.delete();
        case (parse_st)
            SEEK:
            begin
                if (hunt_win == 16'h0000 && b == pes2ts_pkg::START_LAST)
                begin
                    parse_st = HEADER;
                    hdr_idx  = 2'd0;
                    hunt_win = 16'hFFFF;
                end
                else
                    hunt_win = {hunt_win[7:0], b};
            end
            HEADER:
            begin
                if (hdr_idx == 2'd0)
                begin
                    sid_m   = b;
                    hdr_idx = 2'd1;
                end
                else if (hdr_idx == 2'd1)
                begin
                    len_hi_m = b;
                    hdr_idx  = 2'd2;
                end
                else
                begin
                    total   = {1'b0, len_hi_m, b} + pes2ts_pkg::PES_HDR;
                    hdr_idx = 2'd0;
                    if (!is_audio_id(sid_m) && !is_video_id(sid_m))
                    begin
                        // unknown id: swallow the rest of the packet silently
                        dropped_pkts++;
                        remaining = total - pes2ts_pkg::PES_HDR;
                        if (remaining == 17'd0)
                            resume_seek();
                        else
                            parse_st = DISCARD;
                    end
                    else
                    begin
                        video_m   = is_video_id(sid_m);
                        first_m   = 1'b1;
                        remaining = total;
                        if (video_m)
                            video_pkts++;
                        else
                            audio_pkts++;
                        ts_header();
                        // the PES header itself goes out as payload
                        payload_byte(8'h00);
                        payload_byte(8'h00);
                        payload_byte(pes2ts_pkg::START_LAST);
                        payload_byte(sid_m);
                        payload_byte(len_hi_m);
                        payload_byte(b);
                        if (remaining == 17'd0)
                            resume_seek();
                        else
                            parse_st = PAYLOAD;
                    end
                end
            end
            PAYLOAD:
            begin
                payload_byte(b);
                if (remaining == 17'd0)
                    resume_seek();
            end
            default:
            begin
                remaining = remaining - 17'd1;
                if (remaining == 17'd0)
                    resume_seek();
            end
        endcase
        if (step_res.size() > 0)
            step_res[step_res.size() - 1].last = 1'b1;
        foreach (step_res[i])
            ts_exp.push_back(step_res[i]);
    endfunction

    // ------------------------------------------------------------------
    // Result checking against the oldest expected TS result.
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin : check_result
            pes2ts_pkg::res_t want;
            if (ts_exp.size() == 0)
            begin
                $display({"%0t: unexpected result, expected none ",
                          "actual byte=%02h rep=%0d start=%b last=%b"},
                         $time, out_byte, repeat_count, ts_start, last);
                failures++;
            end
            else
            begin
                want = ts_exp.pop_front();
                compare_field("out_byte", want.data, out_byte);
                compare_field("repeat_count", want.rep, repeat_count);
                compare_field("ts_start", want.start, ts_start);
                compare_field("last", want.last, last);
            end
            results_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Receiver backpressure: switches at random between free flow, sparse random
    // stalls, a periodic pattern and heavy stalling.
    // ------------------------------------------------------------------
    stall_t stall_mode = FLOW;
    int     stall_left = 0;

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_t'($urandom_range(0, 3));
            stall_left = $urandom_range(8, 60);
        end
        stall_left--;
        case (stall_mode)
            FLOW:     out_stall <= 1'b0;
            SPARSE:   out_stall <= ($urandom_range(0, 9) < 3);
            PERIODIC: out_stall <= (stall_left % 4 == 0);
            default:  out_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    // ------------------------------------------------------------------
    // Sender: one item per call, in bursts of random length with random
    // gaps between them. Long bursts with no gap show up too.
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_byte(b);
        burst_left--;
        items_sent++;
    endtask

    // Start code, stream id, 16-bit length and random payload. A keep count
    // of zero or more, below the packet's size, cuts it short after that many bytes.
    task automatic send_pes(input logic [7:0] sid, input int len, input int keep);
        logic [7:0] pkt[$];
        int         n;
        pkt = '{8'h00, 8'h00, pes2ts_pkg::START_LAST, sid, len[15:8], len[7:0]};
        repeat (len)
            pkt.push_back(($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom));
        n = (keep >= 0 && keep < pkt.size()) ? keep : pkt.size();
        for (int i = 0; i < n; i++)
            push_byte(pkt[i]);
        if (is_audio_id(sid) || is_video_id(sid))
            stream_bytes += n;
    endtask

    // Drains the block; only after this may the PID registers change.
    task automatic wait_idle();
        in_valid   <= 1'b0;
        burst_left = 0;
        while (ts_exp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_pids(input logic [12:0] vpid, input logic [12:0] apid);
        cfg_valid <= 1'b1;
        cfg_index <= pes2ts_pkg::REG_VIDEO_PID;
        cfg_data  <= vpid;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        video_pid_m = vpid;
        cfg_index <= pes2ts_pkg::REG_AUDIO_PID;
        cfg_data  <= apid;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        audio_pid_m = apid;
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // PIDs still at their reset value; zero-length packets fit one short TS
    // packet with 176 bytes of stuffing.
    task automatic test_reset_pids();
        send_pes(8'hC0, 0, -1);
        send_pes(8'hEF, 0, -1);
        send_pes(pes2ts_pkg::SID_PRIV1, 1, -1);
        wait_idle();
    endtask

    // Edges of the audio and video id ranges, and ids that get dropped.
    task automatic test_stream_ids();
        set_pids(13'h1FFF, 13'h0000);
        send_pes(pes2ts_pkg::SID_AUD_HI, 2, -1);
        send_pes(pes2ts_pkg::SID_VID_LO, 3, -1);
        send_pes(8'hBC, 3, -1);
        send_pes(8'hF0, 0, -1);
        send_pes(8'hBF, 5, -1);
        send_pes(8'hBE, 1, -1);
        wait_idle();
        set_pids(13'h0000, 13'h1FFF);
        send_pes(8'hE7, 1, -1);
        send_pes(8'hD5, 1, -1);
        wait_idle();
    endtask

    // Noise, a run of more than two zeros before 01, and a packet whose
    // payload ends in 00 00 followed by 01: that must not be a start code
    // because the hunt window restarts after every packet.
    task automatic test_start_code_hunt();
        logic [7:0] seq [22] = '{8'hFF, 8'h00, 8'h01, 8'h00,
                                 8'h00, 8'h00, 8'h01, 8'hC1, 8'h00, 8'h02, 8'h00, 8'h00,
                                 8'h01, 8'hC0, 8'h00, 8'h00, 8'h00, 8'h00,
                                 8'h01, 8'hC0, 8'h00, 8'h00};
        set_pids(13'h1F00, 13'h00FF);
        foreach (seq[i])
            push_byte(seq[i]);
        wait_idle();
    endtask

    // Chunk edge: a packet one byte longer than a TS payload fills the first
    // TS packet exactly with no adaptation field, then opens a second one in
    // mid-stream whose single byte sits behind a 181-byte stuffing run.
    task automatic test_chunk_boundaries();
        set_pids(13'($urandom), 13'($urandom));
        send_pes(8'hE0, 179, -1);
        wait_idle();
    endtask

    // Together with the packets sent before, both continuity counters go
    // past 15 and wrap.
    task automatic test_counter_wrap();
        set_pids(13'h0AAA, 13'h1555);
        repeat (12)
        begin
            send_pes(8'hE3, 0, -1);
            send_pes(8'hC7, 0, -1);
        end
        wait_idle();
    endtask

    // Mostly well-formed packets with random ids, lengths and payload; the
    // rest is hunt noise, dropped ids and packets cut short.
    task automatic test_random_stream();
        int         seg_goal;
        int         pick;
        int         len;
        logic [7:0] sid;
        for (int seg = 0; seg < RANDOM_SEGS; seg++)
        begin
            set_pids(13'($urandom), 13'($urandom));
            seg_goal = stream_bytes + RANDOM_ITEMS / RANDOM_SEGS;
            while (stream_bytes < seg_goal)
            begin
                pick = $urandom_range(0, 99);
                if (pick >= 90)
                begin
                    // hunt noise, heavy in zeros and ones
                    repeat ($urandom_range(1, 8))
                        push_byte(($urandom_range(0, 2) == 0) ? 8'($urandom)
                                                              : 8'($urandom_range(0, 1)));
                end
                else
                begin
                    if (pick < 30)
                        sid = 8'($urandom_range(pes2ts_pkg::SID_AUD_LO,
                                                pes2ts_pkg::SID_AUD_HI));
                    else if (pick < 40)
                        sid = pes2ts_pkg::SID_PRIV1;
                    else if (pick < 75)
                        sid = 8'($urandom_range(pes2ts_pkg::SID_VID_LO,
                                                pes2ts_pkg::SID_VID_HI));
                    else
                    begin
                        sid = 8'($urandom);
                        while (is_audio_id(sid) || is_video_id(sid))
                            sid = 8'($urandom);
                    end
                    len = $urandom_range(0, 99);
                    if (len < 85)
                        len = $urandom_range(0, 12);
                    else
                        len = $urandom_range(13, 30);
                    if ($urandom_range(0, 9) == 0)
                        send_pes(sid, len, $urandom_range(1, len + 5));
                    else
                        send_pes(sid, len, -1);
                end
            end
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_pids();
        test_stream_ids();
        test_start_code_hunt();
        test_chunk_boundaries();
        test_counter_wrap();
        test_random_stream();

        wait_idle();
        repeat (20) @(posedge clk);
        if (ts_exp.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, ts_exp.size());
            failures++;
        end

        $display("Sent %0d bytes: %0d audio, %0d video and %0d dropped PES packets.",
                 items_sent, audio_pkts, video_pkts, dropped_pkts);
        $display("Checked %0d TS results, %0d stuffing runs, %0d failures.",
                 results_checked, stuffing_runs, failures);
        if (failures == 0)
            $display("pes_to_ts_packetizer_unit regression: pass");
        else
            $display("pes_to_ts_packetizer_unit regression: fail");
        $finish;
    end

    // Hang guard, far above the slowest legal run.
    initial
    begin
        #2000000;
        $display("pes_to_ts_packetizer_unit regression: fail");
        $finish;
    end

endmodule
